// File: hw/rtl/mbd_pkg.sv
// Package for the 2x2 box-filter mip level downsampler.
// Holds sizes, the register index codes and the dimension clamp.
// No dependencies.
`default_nettype none

package mbd_pkg;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned MAX_HEIGHT   = 4096;
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned FIELD_BITS   = CHANNEL_BITS - 1;   // quarter pair sum field
  localparam int unsigned PAIR_BITS    = 4 * FIELD_BITS;     // four packed fields
  localparam int unsigned LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int unsigned DIM_BITS     = 13;                 // register width
  localparam int unsigned CNT_BITS     = $clog2(MAX_WIDTH);  // column / row counter
  localparam int unsigned COL_BITS     = $clog2(LINE_DEPTH); // output column
  localparam int unsigned IDX_BITS     = 1;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Zero acts as one, oversized values saturate at the limit
  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v,
                                                  input logic [DIM_BITS-1:0] limit);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mbd_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mipmap_box_downsample.sv
// Top level of the 2x2 box-filter mip level downsampler (RGBA8).
// Depends on mbd_pkg and mbd_ram (line store of even-row pair sums).
`default_nettype none

// Channel   Handshake                 Payload
// -------   ------------------------  -------------------------------------------
// input     in_valid_i / in_ready_o   in_red_i, in_green_i, in_blue_i, in_alpha_i
// output    out_valid_o / out_ready_i out_red_o .. out_alpha_o, out_last_o
// config    cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One texel is accepted per cycle; a result for the texel that completes its 2x2
// block passes the line store read, then the output register.
// The line store read at accept time sets the latency; throughput is one item
// per cycle as long as the output side takes results.
// Reset sets both dimensions to 256 and starts a level at texel (0,0).
// Any register write restarts the level. A stalled output holds the middle
// stage; input is accepted again as soon as that stage can move.

module mipmap_box_downsample
  import mbd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // config
  input  wire logic                       cfg_we_i,
  input  wire logic [mbd_pkg::IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [mbd_pkg::DIM_BITS-1:0] cfg_wdata_i,
  // source texels
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [mbd_pkg::CHANNEL_BITS-1:0] in_red_i,
  input  wire logic [mbd_pkg::CHANNEL_BITS-1:0] in_green_i,
  input  wire logic [mbd_pkg::CHANNEL_BITS-1:0] in_blue_i,
  input  wire logic [mbd_pkg::CHANNEL_BITS-1:0] in_alpha_i,
  // downsampled texels
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [mbd_pkg::CHANNEL_BITS-1:0] out_red_o,
  output logic [mbd_pkg::CHANNEL_BITS-1:0] out_green_o,
  output logic [mbd_pkg::CHANNEL_BITS-1:0] out_blue_o,
  output logic [mbd_pkg::CHANNEL_BITS-1:0] out_alpha_o,
  output logic                            out_last_o
);

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0]  src_w_q, src_h_q;
  logic [CNT_BITS-1:0]  col_cnt_q, col_cnt_d;
  logic [CNT_BITS-1:0]  row_cnt_q, row_cnt_d;
  logic [PAIR_BITS-1:0] hpair_q, hpair_d;

  logic                 w_is1, h_is1;
  logic [CNT_BITS-1:0]  out_w, out_h;
  logic                 col_wrap, row_wrap;
  logic [COL_BITS-1:0]  col;
  logic [PAIR_BITS-1:0] quarters;
  logic                 accept;
  logic                 pair_done;
  logic                 store_we;
  logic                 emit;
  logic                 last;

  logic                 s1_valid_q;
  logic [PAIR_BITS-1:0] s1_pair_q;
  logic                 s1_own_q;     // other pair is the same horizontal pair
  logic                 s1_last_q;
  logic                 s1_adv;
  logic                 out_free;
  logic [PAIR_BITS-1:0] store_rdata;
  logic [PAIR_BITS-1:0] other;
  logic [CHANNEL_BITS-1:0] sum_ch [4];

  // ---------------------------------------------------------------------------
  // Configuration registers (clamped on write)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_BITS'(256);
      src_h_q <= DIM_BITS'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SOURCE_WIDTH:  src_w_q <= eff_dim(cfg_wdata_i, DIM_BITS'(MAX_WIDTH));
        REG_SOURCE_HEIGHT: src_h_q <= eff_dim(cfg_wdata_i, DIM_BITS'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Level geometry
  // ---------------------------------------------------------------------------
  assign w_is1    = (src_w_q == DIM_BITS'(1));
  assign h_is1    = (src_h_q == DIM_BITS'(1));
  assign out_w    = w_is1 ? CNT_BITS'(1) : src_w_q[DIM_BITS-1:1];
  assign out_h    = h_is1 ? CNT_BITS'(1) : src_h_q[DIM_BITS-1:1];
  assign col_wrap = (DIM_BITS'(col_cnt_q) + DIM_BITS'(1)) >= src_w_q;
  assign row_wrap = (DIM_BITS'(row_cnt_q) + DIM_BITS'(1)) >= src_h_q;
  assign col      = w_is1 ? '0 : col_cnt_q[CNT_BITS-1:1];

  // Quarters packed as four 7-bit fields, red in the low field
  assign quarters = {1'b0, in_alpha_i[CHANNEL_BITS-1:2], 1'b0, in_blue_i[CHANNEL_BITS-1:2],
                     1'b0, in_green_i[CHANNEL_BITS-1:2], 1'b0, in_red_i[CHANNEL_BITS-1:2]};

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Horizontal pairing and vertical decisions for the accepted texel
  // ---------------------------------------------------------------------------
  always_comb begin
    hpair_d   = hpair_q;
    pair_done = 1'b0;
    if (w_is1) begin
      hpair_d   = quarters + quarters;
      pair_done = 1'b1;
    end else if (!col_cnt_q[0]) begin
      if (!col_wrap) begin
        hpair_d = quarters;
      end
    end else begin
      hpair_d   = hpair_q + quarters;  // fields never carry
      pair_done = 1'b1;
    end

    store_we = 1'b0;
    emit     = 1'b0;
    if (pair_done) begin
      if (h_is1) begin
        emit = 1'b1;
      end else if (!row_cnt_q[0]) begin
        store_we = !row_wrap;
      end else begin
        emit = 1'b1;
      end
    end

    last = ((CNT_BITS'(col) + CNT_BITS'(1)) == out_w) &&
           (h_is1 || ((CNT_BITS'(row_cnt_q[CNT_BITS-1:1]) + CNT_BITS'(1)) == out_h));

    // raster counters
    if (!col_wrap) begin
      col_cnt_d = col_cnt_q + CNT_BITS'(1);
      row_cnt_d = row_cnt_q;
    end else begin
      col_cnt_d = '0;
      row_cnt_d = row_wrap ? '0 : row_cnt_q + CNT_BITS'(1);
    end
  end

  // Position and pair state; a config write restarts the level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      hpair_q   <= '0;
    end else if (cfg_we_i) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      hpair_q   <= '0;
    end else if (accept) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      hpair_q   <= hpair_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: even-row pair sums, read by the odd row below
  // ---------------------------------------------------------------------------
  mbd_ram #(
    .WIDTH (PAIR_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && store_we),
    .waddr_i (col),
    .wdata_i (hpair_d),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (store_rdata)
  );

  // ---------------------------------------------------------------------------
  // Middle stage: waits for the line store read data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= emit;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pair_q <= hpair_d;
      s1_own_q  <= h_is1;
      s1_last_q <= last;
    end
  end

  // Per-channel sum of the two pair sums
  assign other = s1_own_q ? s1_pair_q : store_rdata;
  for (genvar c = 0; c < 4; c++) begin : g_sum
    assign sum_ch[c] = CHANNEL_BITS'(s1_pair_q[c*FIELD_BITS +: FIELD_BITS]) +
                       CHANNEL_BITS'(other[c*FIELD_BITS +: FIELD_BITS]);
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_red_o   <= sum_ch[0];
      out_green_o <= sum_ch[1];
      out_blue_o  <= sum_ch[2];
      out_alpha_o <= sum_ch[3];
      out_last_o  <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DIM_BITS'(col_cnt_q) < src_w_q)
    else $error("column counter beyond source width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DIM_BITS'(row_cnt_q) < src_h_q)
    else $error("row counter beyond source height");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty middle stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_pair_q) && $stable(store_rdata)))
    else $error("middle stage changed while stalled");

endmodule

`default_nettype wire

// File: test/tb_mipmap_box_downsample.sv
// Testbench for mipmap_box_downsample: streams RGBA8 texels over many level sizes
// with random stalls on both sides and checks each downsampled item in order.
// Depends on mbd_pkg and the RTL of the downsampler.

module tb_mipmap_box_downsample;
  import mbd_pkg::*;

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_ITEMS    = 70;
  localparam int IDLE_PERCENT    = 27;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red, green, blue, alpha;
  } texel_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red, green, blue, alpha;
    logic                    last;
  } box_t;

  // four quarter pair sums, red in the top field
  typedef logic [3:0][FIELD_BITS-1:0] pair_sum_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [IDX_BITS-1:0]     cfg_idx_i   = '0;
  logic [DIM_BITS-1:0]     cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [CHANNEL_BITS-1:0] in_red_i    = '0;
  logic [CHANNEL_BITS-1:0] in_green_i  = '0;
  logic [CHANNEL_BITS-1:0] in_blue_i   = '0;
  logic [CHANNEL_BITS-1:0] in_alpha_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CHANNEL_BITS-1:0] out_red_o;
  logic [CHANNEL_BITS-1:0] out_green_o;
  logic [CHANNEL_BITS-1:0] out_blue_o;
  logic [CHANNEL_BITS-1:0] out_alpha_o;
  logic                    out_last_o;

  mipmap_box_downsample u_top (.*);

  // Stimulus and scoreboard storage
  texel_t pending_texels[$];
  box_t   predicted_boxes[$];
  texel_t next_texel;
  box_t   new_box;
  box_t   want_box;
  int     mismatches    = 0;
  int     idle_cycles   = 0;
  int     hold_off_reqs = 0;
  int     hold_off_seen = 0;
  int     hold_left     = 0;
  logic   steady        = 1'b0;

  // Predictor state: registers, line store, running pair, position
  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  pair_sum_t           line_pairs[LINE_DEPTH];
  pair_sum_t           run_pair;
  int unsigned         src_col;
  int unsigned         src_row;

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Zero acts as one, large values saturate
  function automatic int unsigned clamp_dim(input logic [DIM_BITS-1:0] v,
                                            input int unsigned limit);
    if (v == '0) return 1;
    return (v > limit) ? limit : int'(v);
  endfunction

  function automatic void restart_level();
    run_pair = '0;
    src_col  = 0;
    src_row  = 0;
  endfunction

  // Advance the 2x2 box predictor by one source texel; 1 when a box completes
  function automatic bit predict_box(input texel_t t, output box_t res);
    int unsigned                  w, h, ow, oh, col;
    int                           c;
    logic [3:0][CHANNEL_BITS-1:0] chans, sums;
    pair_sum_t                    quarters, other;
    bit                           done, emit;
    w     = clamp_dim(width_reg, MAX_WIDTH);
    h     = clamp_dim(height_reg, MAX_HEIGHT);
    ow    = (w == 1) ? 1 : w / 2;
    oh    = (h == 1) ? 1 : h / 2;
    chans = {t.red, t.green, t.blue, t.alpha};
    for (c = 0; c < 4; c++) quarters[c] = FIELD_BITS'(chans[c] >> 2);
    done  = 1'b0;
    emit  = 1'b0;
    col   = 0;
    other = '0;
    res   = '0;

    // horizontal pair: a width of one pairs the texel with itself
    if (w == 1) begin
      for (c = 0; c < 4; c++) run_pair[c] = quarters[c] + quarters[c];
      done = 1'b1;
    end else if (src_col % 2 == 0) begin
      if (src_col + 1 < w) run_pair = quarters;
    end else begin
      for (c = 0; c < 4; c++) run_pair[c] = run_pair[c] + quarters[c];
      done = 1'b1;
      col  = src_col / 2;
    end

    // vertical pair: even rows fill the line store, odd rows complete the box
    if (done && col < LINE_DEPTH) begin
      if (h == 1) begin
        other = run_pair;
        emit  = 1'b1;
      end else if (src_row % 2 == 0) begin
        if (src_row + 1 < h) line_pairs[col] = run_pair;
      end else begin
        other = line_pairs[col];
        emit  = 1'b1;
      end
    end

    if (emit) begin
      for (c = 0; c < 4; c++)
        sums[c] = CHANNEL_BITS'(run_pair[c]) + CHANNEL_BITS'(other[c]);
      {res.red, res.green, res.blue, res.alpha} = sums;
      res.last = (col + 1 == ow) && (h == 1 || src_row / 2 + 1 == oh);
    end

    // position of the next texel, wrapping at the end of the level
    if (src_col + 1 < w) begin
      src_col++;
    end else begin
      src_col = 0;
      src_row = (src_row + 1 < h) ? src_row + 1 : 0;
    end
    return emit;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: out_%s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] rand_channel();
    if ($urandom_range(6) == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return CHANNEL_BITS'($urandom_range(255));
  endfunction

  function automatic void push_texel(input logic [CHANNEL_BITS-1:0] r, g, b, a);
    pending_texels.push_back(texel_t'{r, g, b, a});
  endfunction

  task automatic queue_random(input int unsigned count);
    @(negedge clk_i);
    repeat (count) begin
      pending_texels.push_back(texel_t'{rand_channel(), rand_channel(),
                                        rand_channel(), rand_channel()});
    end
  endtask

  // Wait until every texel is taken and every box has come out
  task automatic drain();
    @(negedge clk_i);
    while (pending_texels.size() != 0 || in_valid_i || predicted_boxes.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; the block restarts its level, so does the predictor
  task automatic write_reg(input cfg_reg_e idx, input logic [DIM_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_SOURCE_WIDTH) width_reg = value;
    else height_reg = value;
    restart_level();
  endtask

  // Source side: one item per handshake, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_texels.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        next_texel = pending_texels.pop_front();
        in_valid_i <= 1'b1;
        in_red_i   <= next_texel.red;
        in_green_i <= next_texel.green;
        in_blue_i  <= next_texel.blue;
        in_alpha_i <= next_texel.alpha;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Sink side: random stalls plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_left     <= HOLD_OFF_CYCLES;
      out_ready_i   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Monitor: predict on accepted texels, compare accepted boxes in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (predict_box({in_red_i, in_green_i, in_blue_i, in_alpha_i}, new_box))
          predicted_boxes.push_back(new_box);
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_boxes.size() == 0) begin
          $display("%0t: unexpected item r %0d g %0d b %0d a %0d last %0d", $time,
                   out_red_o, out_green_o, out_blue_o, out_alpha_o, out_last_o);
          mismatches++;
        end else begin
          want_box = predicted_boxes.pop_front();
          check_field("red", want_box.red, out_red_o);
          check_field("green", want_box.green, out_green_o);
          check_field("blue", want_box.blue, out_blue_o);
          check_field("alpha", want_box.alpha, out_alpha_o);
          check_field("last", want_box.last, out_last_o);
        end
      end
      idle_cycles <= ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) ?
                     0 : idle_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no item moved for %0d cycles, %0d boxes outstanding", $time,
             STALL_LIMIT, predicted_boxes.size());
    $display("Mismatches found");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned w, h, level_size, count, random_sent;
    width_reg  = 13'd256;
    height_reg = 13'd256;
    restart_level();
    random_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size 256x256: first row and the start of the second
    queue_random(256 + 4);
    drain();

    // 2x2 levels back to back: extremes and quarter truncation
    write_reg(REG_SOURCE_WIDTH, 13'd2);
    write_reg(REG_SOURCE_HEIGHT, 13'd2);
    @(negedge clk_i);
    repeat (4) push_texel(8'd255, 8'd255, 8'd255, 8'd255);
    repeat (4) push_texel(8'd0, 8'd0, 8'd0, 8'd0);
    push_texel(8'd3, 8'd7, 8'd251, 8'd128);
    push_texel(8'd4, 8'd8, 8'd252, 8'd129);
    push_texel(8'd1, 8'd2, 8'd3, 8'd255);
    push_texel(8'd254, 8'd253, 8'd0, 8'd6);
    drain();

    // zero dimensions act as one: every texel is its own box
    write_reg(REG_SOURCE_WIDTH, 13'd0);
    write_reg(REG_SOURCE_HEIGHT, 13'd0);
    @(negedge clk_i);
    push_texel(8'd255, 8'd0, 8'd129, 8'd3);
    push_texel(8'd1, 8'd254, 8'd2, 8'd128);
    drain();

    // 3x3: odd last row and column dropped
    write_reg(REG_SOURCE_WIDTH, 13'd3);
    write_reg(REG_SOURCE_HEIGHT, 13'd3);
    queue_random(9);
    drain();

    // long sink hold-off fills the block; then the source waits for all boxes
    write_reg(REG_SOURCE_WIDTH, 13'd4);
    write_reg(REG_SOURCE_HEIGHT, 13'd64);
    queue_random(40);
    hold_off_reqs <= hold_off_reqs + 1;
    drain();
    queue_random(40);
    drain();

    // stretch without any gaps on either side
    write_reg(REG_SOURCE_WIDTH, 13'd6);
    write_reg(REG_SOURCE_HEIGHT, 13'd6);
    @(negedge clk_i);
    steady <= 1'b1;
    queue_random(36 + 7);
    drain();
    steady <= 1'b0;

    // random small levels: whole levels plus a partial one cut by the next write
    while (random_sent < RANDOM_ITEMS) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
      h = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
      case ($urandom_range(4))
        0: write_reg(REG_SOURCE_WIDTH, DIM_BITS'(w));
        1: write_reg(REG_SOURCE_HEIGHT, DIM_BITS'(h));
        default: begin
          write_reg(REG_SOURCE_WIDTH, DIM_BITS'(w));
          write_reg(REG_SOURCE_HEIGHT, DIM_BITS'(h));
        end
      endcase
      level_size = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
      count = level_size * $urandom_range(0, 2) + $urandom_range(1, level_size);
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      queue_random(count);
      random_sent += count;
      drain();
    end

    // widest row, saturated width, single row
    write_reg(REG_SOURCE_WIDTH, 13'd8191);
    write_reg(REG_SOURCE_HEIGHT, 13'd0);
    queue_random(32);
    drain();

    // single column, saturated height
    write_reg(REG_SOURCE_WIDTH, 13'd1);
    write_reg(REG_SOURCE_HEIGHT, 13'd8191);
    queue_random(32);
    drain();

    if (mismatches == 0 && predicted_boxes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
